@@ sv/assert_macros.svh @@
// assertion macros used by the free page finder back end
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen at a rising edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

@@ sv/cfpf_pkg.sv @@
// types and constants for the contiguous free page finder
// used by every module of the block, no dependencies
package cfpf_pkg;

  localparam int ENTRIES_PER_DIR = 1024;
  localparam int WORD_BITS       = 32;
  localparam int WORDS_PER_DIR   = ENTRIES_PER_DIR / WORD_BITS;
  localparam int WORD_IDX_W      = $clog2(WORDS_PER_DIR);
  localparam int BIT_IDX_W       = $clog2(WORD_BITS);
  localparam int PAGE_W          = $clog2(ENTRIES_PER_DIR);
  localparam int RUN_W           = 16;
  localparam int WANT_W          = 15;
  localparam int Q_DEPTH         = 2;
  localparam int Q_PTR_W         = 1;
  localparam int Q_CNT_W         = 2;

  localparam logic [1:0] OP_PAGE_WR = 2'd0;
  localparam logic [1:0] OP_DIR_WR  = 2'd1;
  localparam logic [1:0] OP_SEARCH  = 2'd2;

  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_END   = 2'd1;

  typedef enum logic [1:0] {
    K_PAGE_WR = 2'd0,
    K_DIR_WR  = 2'd1,
    K_SEARCH  = 2'd2,
    K_NOP     = 2'd3
  } cmd_kind_t;

  // classified request as it travels from front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic              in_range;
    logic [3:0]        dir_slot;
    logic [PAGE_W-1:0] page_slot;
    logic              flag;
    logic [WANT_W-1:0] want;
    logic              want_zero;
    logic              want_small;
    logic [2:0]        lvl;
    logic [4:0]        off;
  } cmd_t;

  typedef struct packed {
    logic [3:0] start;
    logic [4:0] end_eff;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

@@ sv/cfpf_front.sv @@
// front end: accepts requests and classifies them for the back end
// depends on cfpf_pkg
module cfpf_front #(
  parameter int DIR_SLOTS = 16
) (
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_operation,
  input  logic [3:0]                        in_dir_slot,
  input  logic [cfpf_pkg::PAGE_W-1:0]       in_page_slot,
  input  logic                              in_flag_value,
  input  logic [cfpf_pkg::WANT_W-1:0]       in_page_count,
  input  cfpf_pkg::back_stat_t              stat,
  input  logic                              q_full,
  output logic                              q_push,
  output cfpf_pkg::cmd_t                    q_cmd
);

  logic [5:0] n6;
  logic [5:0] off6;
  logic [2:0] lvl;

  assign in_stall = q_full || stat.clearing;
  assign q_push   = in_valid && !in_stall;

  assign n6 = in_page_count[5:0];

  // floor(log2) of a small request, used by the in-word window check
  always_comb begin
    priority if (n6[5]) lvl = 3'd5;
    else if (n6[4])     lvl = 3'd4;
    else if (n6[3])     lvl = 3'd3;
    else if (n6[2])     lvl = 3'd2;
    else if (n6[1])     lvl = 3'd1;
    else                lvl = 3'd0;
  end

  assign off6 = n6 - (6'd1 << lvl);

  always_comb begin
    q_cmd.in_range   = (32'(in_dir_slot) < 32'(DIR_SLOTS));
    q_cmd.dir_slot   = in_dir_slot;
    q_cmd.page_slot  = in_page_slot;
    q_cmd.flag       = in_flag_value;
    q_cmd.want       = in_page_count;
    q_cmd.want_zero  = (in_page_count == '0);
    q_cmd.want_small = (in_page_count != '0) &&
                       (in_page_count <= cfpf_pkg::WANT_W'(cfpf_pkg::WORD_BITS));
    q_cmd.lvl        = lvl;
    q_cmd.off        = off6[4:0];
    unique case (in_operation)
      cfpf_pkg::OP_PAGE_WR: q_cmd.kind = cfpf_pkg::K_PAGE_WR;
      cfpf_pkg::OP_DIR_WR:  q_cmd.kind = cfpf_pkg::K_DIR_WR;
      cfpf_pkg::OP_SEARCH:  q_cmd.kind = cfpf_pkg::K_SEARCH;
      default:              q_cmd.kind = cfpf_pkg::K_NOP;
    endcase
  end

endmodule

@@ sv/cfpf_queue.sv @@
// two-entry request queue between front and back end
// depends on cfpf_pkg
module cfpf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cfpf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output cfpf_pkg::cmd_t q_cmd
);

  cfpf_pkg::cmd_t                    slot_r [cfpf_pkg::Q_DEPTH];
  logic [cfpf_pkg::Q_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [cfpf_pkg::Q_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [cfpf_pkg::Q_CNT_W-1:0]      cnt_r, cnt_nxt;

  assign full    = (cnt_r == cfpf_pkg::Q_CNT_W'(cfpf_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/cfpf_back.sv @@
// back end: page map memories, clearing pass, first-fit search engine, result register
// depends on cfpf_pkg and assert_macros.svh
`include "assert_macros.svh"
module cfpf_back #(
  parameter int DIR_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfpf_pkg::cfg_t        cfg,
  input  logic                  q_valid,
  input  cfpf_pkg::cmd_t        q_cmd,
  output logic                  q_pop,
  output cfpf_pkg::back_stat_t  stat,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  out_found,
  output logic [31:0]           out_base_address
);

  localparam int DIR_W      = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
  localparam int PM_ADDR_W  = DIR_W + cfpf_pkg::WORD_IDX_W;
  localparam int PAGE_WORDS = DIR_SLOTS * cfpf_pkg::WORDS_PER_DIR;
  localparam int WB         = cfpf_pkg::WORD_BITS;
  localparam int RW         = cfpf_pkg::RUN_W;
  localparam int WIW        = cfpf_pkg::WORD_IDX_W;
  localparam int BIW        = cfpf_pkg::BIT_IDX_W;

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_PW_RD   = 8'b0000_0100,
    ST_PW_WR   = 8'b0000_1000,
    ST_DIR_RD  = 8'b0001_0000,
    ST_DIR_CHK = 8'b0010_0000,
    ST_SCAN    = 8'b0100_0000,
    ST_RESULT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [WB-1:0]        page_mem [PAGE_WORDS];
  logic                 dir_mem  [DIR_SLOTS];
  logic [WB-1:0]        pm_rdata_r;
  logic                 present_r;
  logic                 pm_we, pm_re, dm_we, dm_re, dm_wdata;
  logic [PM_ADDR_W-1:0] pm_waddr, pm_raddr;
  logic [WB-1:0]        pm_wdata;
  logic [DIR_W-1:0]     dm_waddr, dm_raddr;

  // control and working registers
  cfpf_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [PM_ADDR_W-1:0] clr_r, clr_nxt;
  logic [4:0]           dir_r, dir_nxt;
  logic [RW-1:0]        run_r, run_nxt;
  logic [4:0]           bdir_r, bdir_nxt;
  logic [cfpf_pkg::PAGE_W-1:0] bpage_r, bpage_nxt;
  logic                 found_r, found_nxt;
  logic [WIW-1:0]       issue_w_r, issue_w_nxt;
  logic                 issue_on_r, issue_on_nxt;
  logic                 dvld_r, dvld_nxt;
  logic [WIW-1:0]       dword_r, dword_nxt;
  logic                 out_valid_r;
  logic                 out_found_r;
  logic [31:0]          out_base_r;
  logic                 out_load;

  // index conversions
  logic [DIR_W+4:0]     dir_ext;
  logic [DIR_W+3:0]     cdir_ext, qdir_ext;
  logic [DIR_W-1:0]     dir_idx, cdir_idx, qdir_idx;
  logic [PM_ADDR_W-1:0] cmd_paddr;

  // word evaluation
  logic [WB-1:0]        used_w;
  logic [WB-1:0]        rlev [6];
  logic [WB-1:0]        win_sel, win;
  logic [BIW-1:0]       win_pos;
  logic [BIW:0]         t0;
  logic [BIW-1:0]       hi_used;
  logic                 any_used;
  logic                 hit_a, hit_b;
  logic [RW-1:0]        want_ext;
  logic [RW-1:0]        run_abs;
  logic [4:0]           dir_inc;
  logic                 dir_last;
  logic [WB-1:0]        pw_data;

  assign dir_ext  = {{DIR_W{1'b0}}, dir_r};
  assign dir_idx  = dir_ext[DIR_W-1:0];
  assign cdir_ext = {{DIR_W{1'b0}}, cmd_r.dir_slot};
  assign cdir_idx = cdir_ext[DIR_W-1:0];
  assign qdir_ext = {{DIR_W{1'b0}}, q_cmd.dir_slot};
  assign qdir_idx = qdir_ext[DIR_W-1:0];
  assign cmd_paddr = {cdir_idx, cmd_r.page_slot[cfpf_pkg::PAGE_W-1:BIW]};

  assign stat.clearing = (state_r == ST_CLEAR);

  assign want_ext = {1'b0, cmd_r.want};
  assign run_abs  = run_r + RW'(cfpf_pkg::ENTRIES_PER_DIR);
  assign dir_inc  = dir_r + 5'd1;
  assign dir_last = (dir_inc >= cfg.end_eff);

  always_comb begin
    pw_data = pm_rdata_r;
    pw_data[cmd_r.page_slot[BIW-1:0]] = cmd_r.flag;
  end

  // rlev[k][s]: pages s .. s+2^k-1 of the word are all free
  always_comb begin
    used_w  = pm_rdata_r;
    rlev[0] = ~pm_rdata_r;
    for (int k = 0; k < 5; k++) begin
      rlev[k+1] = rlev[k] & (rlev[k] >> (2 ** k));
    end
  end

  // two overlapping power-of-two windows cover a window of any small length
  assign win_sel = rlev[cmd_r.lvl];
  assign win     = cmd_r.want_small ? (win_sel & (win_sel >> cmd_r.off)) : '0;

  always_comb begin
    win_pos  = '0;
    t0       = (BIW+1)'(WB);
    hi_used  = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (win[i]) begin
        win_pos = BIW'(i);
      end
      if (used_w[i]) begin
        t0 = (BIW+1)'(i);
      end
    end
    for (int i = 0; i < WB; i++) begin
      if (used_w[i]) begin
        hi_used = BIW'(i);
      end
    end
    any_used = |used_w;
  end

  // a run carried in from below always completes before a window inside the word
  assign hit_a = ((run_r + RW'(t0)) >= want_ext);
  assign hit_b = |win;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    clr_nxt      = clr_r;
    dir_nxt      = dir_r;
    run_nxt      = run_r;
    bdir_nxt     = bdir_r;
    bpage_nxt    = bpage_r;
    found_nxt    = found_r;
    issue_w_nxt  = issue_w_r;
    issue_on_nxt = issue_on_r;
    dvld_nxt     = 1'b0;
    dword_nxt    = dword_r;
    q_pop        = 1'b0;
    out_load     = 1'b0;
    pm_we        = 1'b0;
    pm_waddr     = clr_r;
    pm_wdata     = '0;
    pm_re        = 1'b0;
    pm_raddr     = {dir_idx, issue_w_r};
    dm_we        = 1'b0;
    dm_waddr     = clr_r[DIR_W-1:0];
    dm_wdata     = 1'b0;
    dm_re        = 1'b0;
    dm_raddr     = dir_idx;

    unique case (state_r)
      ST_CLEAR: begin
        pm_we = 1'b1;
        dm_we = (32'(clr_r) < 32'(DIR_SLOTS));
        clr_nxt = clr_r + 1'b1;
        if (clr_r == PM_ADDR_W'(PAGE_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          found_nxt = 1'b0;
          unique case (q_cmd.kind)
            cfpf_pkg::K_PAGE_WR: begin
              state_nxt = q_cmd.in_range ? ST_PW_RD : ST_RESULT;
            end
            cfpf_pkg::K_DIR_WR: begin
              dm_we     = q_cmd.in_range;
              dm_waddr  = qdir_idx;
              dm_wdata  = q_cmd.flag;
              state_nxt = ST_RESULT;
            end
            cfpf_pkg::K_SEARCH: begin
              dir_nxt = {1'b0, cfg.start};
              run_nxt = '0;
              if (q_cmd.want_zero || ({1'b0, cfg.start} >= cfg.end_eff)) begin
                state_nxt = ST_RESULT;
              end else begin
                state_nxt = ST_DIR_RD;
              end
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end

      // read-modify-write of the word holding the used bit
      ST_PW_RD: begin
        pm_re     = 1'b1;
        pm_raddr  = cmd_paddr;
        state_nxt = ST_PW_WR;
      end

      ST_PW_WR: begin
        pm_we     = 1'b1;
        pm_waddr  = cmd_paddr;
        pm_wdata  = pw_data;
        state_nxt = ST_RESULT;
      end

      ST_DIR_RD: begin
        dm_re     = 1'b1;
        state_nxt = ST_DIR_CHK;
      end

      ST_DIR_CHK: begin
        if (!present_r) begin
          // absent slot is one whole free run
          run_nxt = run_abs;
          if (run_r == '0) begin
            bdir_nxt  = dir_r;
            bpage_nxt = '0;
          end
          if (run_abs >= want_ext) begin
            found_nxt = 1'b1;
            state_nxt = ST_RESULT;
          end else begin
            dir_nxt   = dir_inc;
            state_nxt = dir_last ? ST_RESULT : ST_DIR_RD;
          end
        end else begin
          issue_w_nxt  = '0;
          issue_on_nxt = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (issue_on_r) begin
          pm_re       = 1'b1;
          dvld_nxt    = 1'b1;
          dword_nxt   = issue_w_r;
          issue_w_nxt = issue_w_r + 1'b1;
          if (issue_w_r == WIW'(cfpf_pkg::WORDS_PER_DIR - 1)) begin
            issue_on_nxt = 1'b0;
          end
        end
        if (dvld_r) begin
          priority if (hit_a) begin
            found_nxt = 1'b1;
            if (run_r == '0) begin
              bdir_nxt  = dir_r;
              bpage_nxt = {dword_r, BIW'(0)};
            end
            issue_on_nxt = 1'b0;
            dvld_nxt     = 1'b0;
            state_nxt    = ST_RESULT;
          end else if (hit_b) begin
            found_nxt    = 1'b1;
            bdir_nxt     = dir_r;
            bpage_nxt    = {dword_r, win_pos};
            issue_on_nxt = 1'b0;
            dvld_nxt     = 1'b0;
            state_nxt    = ST_RESULT;
          end else begin
            if (any_used) begin
              // free tail above the highest used page starts the next run
              run_nxt   = RW'(WB - 1) - RW'(hi_used);
              bdir_nxt  = dir_r;
              bpage_nxt = {dword_r, hi_used + 1'b1};
            end else begin
              run_nxt = run_r + RW'(WB);
              if (run_r == '0) begin
                bdir_nxt  = dir_r;
                bpage_nxt = {dword_r, BIW'(0)};
              end
            end
            if (dword_r == WIW'(cfpf_pkg::WORDS_PER_DIR - 1)) begin
              dvld_nxt     = 1'b0;
              issue_on_nxt = 1'b0;
              dir_nxt      = dir_inc;
              state_nxt    = dir_last ? ST_RESULT : ST_DIR_RD;
            end
          end
        end
      end

      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      issue_on_r  <= 1'b0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      issue_on_r <= issue_on_nxt;
      dvld_r     <= dvld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    dir_r     <= dir_nxt;
    run_r     <= run_nxt;
    bdir_r    <= bdir_nxt;
    bpage_r   <= bpage_nxt;
    found_r   <= found_nxt;
    issue_w_r <= issue_w_nxt;
    dword_r   <= dword_nxt;
    if (out_load) begin
      out_found_r <= found_r;
      out_base_r  <= found_r ? {5'd0, bdir_r, bpage_r, 12'd0} : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      page_mem[pm_waddr] <= pm_wdata;
    end
    if (pm_re) begin
      pm_rdata_r <= page_mem[pm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dir_mem[dm_waddr] <= dm_wdata;
    end
    if (dm_re) begin
      present_r <= dir_mem[dm_raddr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_base_address = out_base_r;

  `ASSERT_CLK(a_pop_only_idle, q_pop |-> (state_r == ST_IDLE) && q_valid, "pop outside idle")
  `ASSERT_CLK(a_scan_in_window, (state_r == ST_SCAN) |-> (dir_r < cfg.end_eff), "scan past end")
  `ASSERT_CLK(a_data_only_scan, dvld_r |-> (state_r == ST_SCAN), "word data outside scan")
  `ASSERT_NEVER(a_nf_base, out_valid_r && !out_found_r && (out_base_r != 32'd0), "base not zero")

endmodule

@@ sv/contiguous_free_page_finder.sv @@
// channel  | handshake          | payload
// in       | in_valid/in_stall  | operation, dir_slot, page_slot, flag_value, page_count
// out      | out_valid/out_stall| found, base_address
// cfg      | cfg_valid/cfg_ready| cfg_index, cfg_data
// after reset a clearing pass zeroes the page and directory maps; no request is taken
// a page write reads, then rewrites its word; a search scans the words of present slots
// the page memory read port, one 32-bit word per cycle, sets the search time
// a finished result waits in the output register while the queue takes new requests
// top level: configuration registers, front end, queue, back end; depends on cfpf_pkg
module contiguous_free_page_finder #(
  parameter int DIR_SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [3:0]                  in_dir_slot,
  input  logic [9:0]                  in_page_slot,
  input  logic                        in_flag_value,
  input  logic [14:0]                 in_page_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [31:0]                 out_base_address,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [4:0]                  cfg_data
);

  logic [3:0]           start_r;
  logic [4:0]           end_r;
  cfpf_pkg::cfg_t       cfg;
  cfpf_pkg::back_stat_t stat;
  cfpf_pkg::cmd_t       push_cmd, q_cmd;
  logic                 q_push, q_full, q_pop, q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 4'd0;
      end_r   <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cfpf_pkg::CFG_START) begin
        start_r <= cfg_data[3:0];
      end else if (cfg_index == cfpf_pkg::CFG_END) begin
        end_r <= cfg_data;
      end
    end
  end

  // end slot clamped to the map size
  always_comb begin
    cfg.start = start_r;
    if (32'(end_r) > 32'(DIR_SLOTS)) begin
      cfg.end_eff = 5'(DIR_SLOTS);
    end else begin
      cfg.end_eff = end_r;
    end
  end

  cfpf_front #(
    .DIR_SLOTS(DIR_SLOTS)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_dir_slot   (in_dir_slot),
    .in_page_slot  (in_page_slot),
    .in_flag_value (in_flag_value),
    .in_page_count (in_page_count),
    .stat          (stat),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  cfpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  cfpf_back #(
    .DIR_SLOTS(DIR_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_base_address (out_base_address)
  );

endmodule

@@ verif/contiguous_free_page_finder_tb.sv @@
`timescale 1ns / 100ps
// testbench for contiguous_free_page_finder: directed table, then randomized request phases
// self-checking against a shadow page map; depends on cfpf_pkg and the block's top level
module contiguous_free_page_finder_tb;

  localparam int DIR_SLOTS       = 16;
  localparam int ENTRIES_PER_DIR = cfpf_pkg::ENTRIES_PER_DIR;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int TAIL_CYCLES     = 600;
  localparam int PHASES          = 10;
  localparam int PHASE_ITEMS     = 100;

  localparam logic [1:0] OP_PAGE_WR = cfpf_pkg::OP_PAGE_WR;
  localparam logic [1:0] OP_DIR_WR  = cfpf_pkg::OP_DIR_WR;
  localparam logic [1:0] OP_SEARCH  = cfpf_pkg::OP_SEARCH;
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_START  = cfpf_pkg::CFG_START;
  localparam logic [1:0] CFG_END    = cfpf_pkg::CFG_END;
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  dir;
    logic [9:0]  page;
    logic        flag;
    logic [14:0] count;
  } map_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] base;
  } run_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  dir;
    logic [9:0]  page;
    logic        flag;
    logic [14:0] count;
    logic        known;
    logic        known_found;
    logic [31:0] known_base;
  } seed_row_t;

  localparam int SEED_N = 24;
  localparam seed_row_t SEED_ROWS [SEED_N] = '{
    '{OP_SEARCH,  4'd0,  10'd0,    1'b0, 15'd0,     1'b1, 1'b0, 32'h0},
    '{OP_SEARCH,  4'd0,  10'd0,    1'b0, 15'd1,     1'b1, 1'b1, 32'h0},
    '{OP_SEARCH,  4'd15, 10'd1023, 1'b1, 15'd16384, 1'b1, 1'b1, 32'h0},
    '{OP_SEARCH,  4'd0,  10'd0,    1'b0, 15'd16385, 1'b1, 1'b0, 32'h0},
    '{OP_UNUSED,  4'd15, 10'd1023, 1'b1, 15'd32767, 1'b1, 1'b0, 32'h0},
    '{OP_DIR_WR,  4'd0,  10'd0,    1'b1, 15'd0,     1'b1, 1'b0, 32'h0},
    '{OP_PAGE_WR, 4'd0,  10'd0,    1'b1, 15'd0,     1'b1, 1'b0, 32'h0},
    '{OP_SEARCH,  4'd0,  10'd0,    1'b0, 15'd1,     1'b1, 1'b1, 32'h0000_1000},
    '{OP_PAGE_WR, 4'd0,  10'd1023, 1'b1, 15'd0,     1'b1, 1'b0, 32'h0},
    '{OP_SEARCH,  4'd0,  10'd0,    1'b0, 15'd1023,  1'b0, 1'b0, 32'h0},
    '{OP_SEARCH,  4'd0,  10'd0,    1'b0, 15'd1022,  1'b0, 1'b0, 32'h0},
    '{OP_DIR_WR,  4'd15, 10'd0,    1'b1, 15'd0,     1'b1, 1'b0, 32'h0},
    '{OP_PAGE_WR, 4'd15, 10'd1023, 1'b1, 15'd32767, 1'b1, 1'b0, 32'h0},
    '{OP_SEARCH,  4'd0,  10'd0,    1'b0, 15'd15359, 1'b0, 1'b0, 32'h0},
    '{OP_SEARCH,  4'd0,  10'd0,    1'b0, 15'd15360, 1'b0, 1'b0, 32'h0},
    '{OP_DIR_WR,  4'd0,  10'd1023, 1'b0, 15'd0,     1'b1, 1'b0, 32'h0},
    '{OP_SEARCH,  4'd0,  10'd0,    1'b0, 15'd1,     1'b1, 1'b1, 32'h0},
    '{OP_DIR_WR,  4'd0,  10'd0,    1'b1, 15'd0,     1'b1, 1'b0, 32'h0},
    '{OP_SEARCH,  4'd0,  10'd0,    1'b0, 15'd2,     1'b0, 1'b0, 32'h0},
    '{OP_PAGE_WR, 4'd0,  10'd0,    1'b0, 15'd0,     1'b1, 1'b0, 32'h0},
    '{OP_PAGE_WR, 4'd15, 10'd1023, 1'b0, 15'd0,     1'b1, 1'b0, 32'h0},
    '{OP_SEARCH,  4'd0,  10'd0,    1'b0, 15'd16384, 1'b0, 1'b0, 32'h0},
    '{OP_PAGE_WR, 4'd0,  10'd1023, 1'b0, 15'd32767, 1'b1, 1'b0, 32'h0},
    '{OP_SEARCH,  4'd0,  10'd0,    1'b0, 15'd16384, 1'b0, 1'b0, 32'h0}
  };

  // window settings per phase, extremes and out-of-range data included
  localparam logic [4:0] PH_START [PHASES] = '{5'd0, 5'd15, 5'd15, 5'd8, 5'd3,
                                               5'd0, 5'd21, 5'd7, 5'd0, 5'd0};
  localparam logic [4:0] PH_END   [PHASES] = '{5'd0, 5'd16, 5'd31, 5'd8, 5'd12,
                                               5'd31, 5'd17, 5'd5, 5'd1, 5'd16};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [3:0]  in_dir_slot = '0;
  logic [9:0]  in_page_slot = '0;
  logic        in_flag_value = 1'b0;
  logic [14:0] in_page_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [31:0] out_base_address;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  // typed-in expectation that travels with a directed request
  logic        req_known = 1'b0;
  logic        req_known_found = 1'b0;
  logic [31:0] req_known_base = '0;

  // shadow of the page map and the search window
  logic        shadow_present [DIR_SLOTS];
  logic        shadow_used [DIR_SLOTS*ENTRIES_PER_DIR];
  logic [3:0]  win_start = 4'd0;
  logic [4:0]  win_end = 5'd16;

  run_result_t expected_runs [$];
  run_result_t exp_head;
  run_result_t pred_res;
  map_req_t    seen_req;
  int          reqs_sent = 0;
  int          results_seen = 0;
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  int          stall_mode = 0;
  int          stall_mode_left = 0;
  int          stall_run_left = 0;

  contiguous_free_page_finder #(
    .DIR_SLOTS(DIR_SLOTS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_dir_slot(in_dir_slot),
    .in_page_slot(in_page_slot),
    .in_flag_value(in_flag_value),
    .in_page_count(in_page_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_found(out_found),
    .out_base_address(out_base_address),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // first fit over the window; absent slots count as a full run of free pages
  function automatic run_result_t find_free_run(input logic [14:0] want);
    run_result_t res;
    int          lim;
    int unsigned run;
    logic [31:0] first;
    int          d;
    int          p;
    res = '0;
    run = 0;
    first = '0;
    if (want == 0) return res;
    lim = (win_end > DIR_SLOTS) ? DIR_SLOTS : int'(win_end);
    for (d = int'(win_start); d < lim; d++) begin
      if (!shadow_present[d]) begin
        if (run == 0) first = 32'(d) << 22;
        run += ENTRIES_PER_DIR;
        if (run >= want) begin
          res.found = 1'b1;
          res.base = first;
          return res;
        end
      end else begin
        for (p = 0; p < ENTRIES_PER_DIR; p++) begin
          if (shadow_used[d*ENTRIES_PER_DIR + p]) begin
            run = 0;
          end else begin
            if (run == 0) first = (32'(d) << 22) | (32'(p) << 12);
            run++;
            if (run >= want) begin
              res.found = 1'b1;
              res.base = first;
              return res;
            end
          end
        end
      end
    end
    return res;
  endfunction

  function automatic run_result_t apply_map_req(input map_req_t r);
    run_result_t res;
    res = '0;
    case (r.op)
      OP_PAGE_WR: begin
        if (r.dir < DIR_SLOTS) shadow_used[int'(r.dir)*ENTRIES_PER_DIR + int'(r.page)] = r.flag;
      end
      OP_DIR_WR: begin
        if (r.dir < DIR_SLOTS) shadow_present[r.dir] = r.flag;
      end
      OP_SEARCH: begin
        res = find_free_run(r.count);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic map_req_t rand_req();
    map_req_t r;
    r.op    = 2'($urandom);
    r.dir   = 4'($urandom);
    r.page  = 10'($urandom);
    r.flag  = 1'($urandom);
    r.count = 15'($urandom);
    return r;
  endfunction

  // page counts around the hole just written, directory slot sizes and the map size
  function automatic logic [14:0] pick_count(input int unsigned hole);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 15'd0 : 15'($urandom);
      1, 2:    return 15'(hole);
      3:       return 15'(hole + 1);
      4:       return (hole > 1) ? 15'(hole - 1) : 15'd1;
      5, 6:    return 15'($urandom_range(1, 64));
      7:       return 15'($urandom_range(1, 4) * 1024 + $urandom_range(0, 2) - 1);
      8:       return 15'($urandom_range(1, 16384));
      default: return 15'(16384 - $urandom_range(0, 1100));
    endcase
  endfunction

  task automatic send_req(input map_req_t r, input logic known = 1'b0,
                          input logic kfound = 1'b0, input logic [31:0] kbase = '0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_operation    <= r.op;
    in_dir_slot     <= r.dir;
    in_page_slot    <= r.page;
    in_flag_value   <= r.flag;
    in_page_count   <= r.count;
    req_known       <= known;
    req_known_found <= kfound;
    req_known_base  <= kbase;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reqs_sent++;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // every request returns one result, so idle means all results are back
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (results_seen < reqs_sent) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    int       sent;
    int       d;
    int       lo;
    int       hi;
    int       len;
    int       p0;
    int       h0;
    int       hl;
    int       i;
    int       ns;
    map_req_t r;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 6) begin
        // usually make a slot present, paint a used stretch with a hole, then search for it
        lo = int'(win_start);
        hi = ((win_end > DIR_SLOTS) ? DIR_SLOTS : int'(win_end)) - 1;
        if (lo <= hi && $urandom_range(0, 9) < 8) d = $urandom_range(lo, hi);
        else d = $urandom_range(0, DIR_SLOTS - 1);
        len = $urandom_range(2, 48);
        case ($urandom_range(0, 3))
          0:       p0 = 0;
          1:       p0 = ENTRIES_PER_DIR - len;
          default: p0 = $urandom_range(0, ENTRIES_PER_DIR - len);
        endcase
        h0 = $urandom_range(0, len - 1);
        hl = $urandom_range(1, len - h0);
        if ($urandom_range(0, 4) != 0) begin
          r = rand_req();
          r.op = OP_DIR_WR;
          r.dir = 4'(d);
          r.flag = 1'b1;
          send_req(r);
          sent++;
        end
        for (i = 0; i < len; i++) begin
          r = rand_req();
          r.op = OP_PAGE_WR;
          r.dir = 4'(d);
          r.page = 10'(p0 + i);
          r.flag = (i >= h0 && i < h0 + hl) ? 1'b0 : 1'b1;
          if ($urandom_range(0, 15) == 0) r.flag = ~r.flag;
          send_req(r);
          sent++;
        end
        ns = $urandom_range(1, 3);
        for (i = 0; i < ns; i++) begin
          r = rand_req();
          r.op = OP_SEARCH;
          r.count = pick_count(hl);
          send_req(r);
          sent++;
        end
      end else begin
        r = rand_req();
        if ($urandom_range(0, 1)) r.count = pick_count($urandom_range(1, 48));
        send_req(r);
        sent++;
      end
    end
  endtask

  // result check, then prediction of newly accepted requests, then window updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_runs.size() == 0) begin
          $error("result with no request waiting: found %0d base %h",
                 out_found, out_base_address);
          fail_count++;
        end else begin
          exp_head = expected_runs.pop_front();
          if (out_found !== exp_head.found) begin
            $error("found: expected %0d, actual %0d", exp_head.found, out_found);
            fail_count++;
          end
          if (out_base_address !== exp_head.base) begin
            $error("base_address: expected %h, actual %h", exp_head.base, out_base_address);
            fail_count++;
          end
        end
        results_seen <= results_seen + 1;
      end
      if (in_valid && !in_stall) begin
        seen_req = '{in_operation, in_dir_slot, in_page_slot, in_flag_value, in_page_count};
        pred_res = apply_map_req(seen_req);
        if (req_known) pred_res = '{req_known_found, req_known_base};
        expected_runs.push_back(pred_res);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START: win_start = cfg_data[3:0];
          CFG_END:   win_end = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // receiver: quiet, coin-flip and long-stall stretches
  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_mode_left <= $urandom_range(50, 400);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_run_left == 0) begin
          out_stall <= ~out_stall;
          stall_run_left <= $urandom_range(1, 40);
        end else begin
          stall_run_left <= stall_run_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    foreach (shadow_present[i]) shadow_present[i] = 1'b0;
    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SEED_N; i++) begin
      send_req('{SEED_ROWS[i].op, SEED_ROWS[i].dir, SEED_ROWS[i].page,
                 SEED_ROWS[i].flag, SEED_ROWS[i].count},
               SEED_ROWS[i].known, SEED_ROWS[i].known_found, SEED_ROWS[i].known_base);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      cfg_write(CFG_START, PH_START[ph]);
      cfg_write(CFG_END, PH_END[ph]);
      cfg_write(CFG_SPARE, 5'($urandom));
      cfg_valid <= 1'b0;
      run_random(PHASE_ITEMS);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_runs.size() != 0) begin
      $error("%0d results never arrived", expected_runs.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ contiguous_free_page_finder.f @@
+incdir+sv
sv/cfpf_pkg.sv
sv/cfpf_front.sv
sv/cfpf_queue.sv
sv/cfpf_back.sv
sv/contiguous_free_page_finder.sv
verif/contiguous_free_page_finder_tb.sv
